// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the cartridge clock block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, held off while reset is high.
`define CRTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define CRTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CRTC_ASSERT(lbl, prop, msg)
`define CRTC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hdl/crtc_pkg.sv =====
// Shared types, constants and helper functions of the cartridge clock block.
package crtc_pkg;

  // Width of the running seconds count (27 to 64).
  localparam int COUNT_BITS = 32;
  // Day field width: one day is more than 2^16 seconds.
  localparam int DAY_BITS   = COUNT_BITS - 16;

  localparam logic [63:0] SECS_PER_DAY  = 64'd86400;
  localparam logic [63:0] SECS_PER_HOUR = 64'd3600;
  localparam logic [63:0] SECS_PER_MIN  = 64'd60;

  // Largest count, split into days / hours / minutes / seconds.
  localparam logic [63:0] COUNT_MAX   = {64{1'b1}} >> (64 - COUNT_BITS);
  localparam logic [63:0] MAX_DAYS    = COUNT_MAX / SECS_PER_DAY;
  localparam logic [63:0] MAX_DAY_REM = COUNT_MAX % SECS_PER_DAY;
  localparam logic [63:0] MAX_HOURS   = MAX_DAY_REM / SECS_PER_HOUR;
  localparam logic [63:0] MAX_MINUTES = (MAX_DAY_REM % SECS_PER_HOUR) / SECS_PER_MIN;
  localparam logic [63:0] MAX_SECONDS = MAX_DAY_REM % SECS_PER_MIN;

  // Day count fold
  localparam int DAY_LIMIT = 511;
  localparam int DAY_FOLD  = 512;

  // Register addresses
  localparam logic [7:0] REG_SECONDS = 8'h08;
  localparam logic [7:0] REG_MINUTES = 8'h09;
  localparam logic [7:0] REG_HOURS   = 8'h0A;
  localparam logic [7:0] REG_DAY_LOW = 8'h0B;
  localparam logic [7:0] REG_DAY_HIGH = 8'h0C;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LATCH = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  // Count held in mixed radix; always normalized and never above the max.
  typedef struct packed {
    logic [DAY_BITS-1:0] days;
    logic [4:0]          hours;
    logic [5:0]          minutes;
    logic [5:0]          seconds;
  } cnt_t;

  // Candidate count after a write, with one spare day bit for overflow.
  typedef struct packed {
    logic [DAY_BITS:0] days;
    logic [4:0]        hours;
    logic [5:0]        minutes;
    logic [5:0]        seconds;
  } wcnt_t;

  localparam cnt_t CNT_MAX = '{
    days:    MAX_DAYS[DAY_BITS-1:0],
    hours:   MAX_HOURS[4:0],
    minutes: MAX_MINUTES[5:0],
    seconds: MAX_SECONDS[5:0]
  };

  // v / 60 for a byte: reciprocal 137 / 2^13 is exact over 0..255.
  function automatic logic [2:0] div60(logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd137;
    return p[15:13];
  endfunction

  function automatic logic [5:0] rem60(logic [7:0] v);
    logic [7:0] q;
    logic [7:0] r;
    q = {5'd0, div60(v)};
    r = v - q * 8'd60;
    return r[5:0];
  endfunction

  // v / 24 for a byte: reciprocal 171 / 2^12 is exact over 0..255.
  function automatic logic [3:0] div24(logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd171;
    return p[15:12];
  endfunction

  function automatic logic [4:0] rem24(logic [7:0] v);
    logic [7:0] q;
    logic [7:0] r;
    q = {4'd0, div24(v)};
    r = v - q * 8'd24;
    return r[4:0];
  endfunction

  // Lexicographic compare of a candidate count against the largest count.
  function automatic logic above_max(wcnt_t w);
    logic [DAY_BITS:0] md;
    md = {1'b0, CNT_MAX.days};
    return (w.days > md) ||
           ((w.days == md) &&
            ((w.hours > CNT_MAX.hours) ||
             ((w.hours == CNT_MAX.hours) &&
              ((w.minutes > CNT_MAX.minutes) ||
               ((w.minutes == CNT_MAX.minutes) &&
                (w.seconds > CNT_MAX.seconds))))));
  endfunction

endpackage

// ===== hdl/cartridge_rtc_registers_core.sv =====
// Top level of the cartridge real-time clock register block.
//
// Usage:
//   Request channel (req_valid / req_stall) carries opcode, reg_address and
//   data. Opcodes: one-second tick, latch write, register read, register
//   write. Every request gives exactly one response on rsp_valid /
//   rsp_stall with read_data (zero for anything but a read of 0x08..0x0C).
//   A request is taken when valid is high and stall is low at a clock edge.
// Timing:
//   One request per cycle while req_stall is low. The state is updated at the
//   edge where the request is taken; the response goes to the output register,
//   or to the skid entry while that holds one not yet taken. Time of day is held
//   as separate seconds, minutes, hours and days counters, so every request is
//   one pass of small adders and compares between state and response registers.
// Back-pressure:
//   Responses go into a two-entry output buffer. req_stall rises only when
//   both entries hold responses not yet taken, and is driven from a
//   register. No response is ever dropped or repeated.
// Reset:
//   rst (synchronous, active high) clears the count, latched registers,
//   halt and carry flags, the latch history and both buffer entries.
`include "assert_macros.svh"

module cartridge_rtc_registers_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] reg_address,
  input  logic [7:0] data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data
);
  import crtc_pkg::*;

  // Clock state
  cnt_t       cnt, cnt_next;
  logic [5:0] latched_seconds, latched_seconds_next;
  logic [5:0] latched_minutes, latched_minutes_next;
  logic [4:0] latched_hours, latched_hours_next;
  logic [8:0] latched_days, latched_days_next;
  logic [7:0] last_latch_byte, last_latch_byte_next;
  logic       halted, halted_next;
  logic       day_carry, day_carry_next;

  // Output buffer
  logic       skid_valid;
  logic [7:0] skid_data;
  logic [7:0] rd_next;

  // Datapath helpers
  op_t               op;
  logic              req_accept;
  logic              rsp_take;
  logic              at_max;
  cnt_t              tick_cnt;
  logic [2:0]        q60_d;
  logic [5:0]        r60_d;
  logic [3:0]        q24_d;
  logic [4:0]        r24_d;
  logic [6:0]        m_sum;
  logic              m_wrap;
  logic [5:0]        m_val;
  logic [2:0]        hour_add;
  logic [5:0]        h_sum;
  logic              h_wrap;
  logic [4:0]        h_val;
  logic [3:0]        day_add;
  logic [DAY_BITS:0] d_sum;
  logic              fold;
  wcnt_t             wide;
  logic              sat_check;

  assign op         = op_t'(opcode);
  assign req_accept = req_valid && !req_stall;
  assign rsp_take   = rsp_valid && !rsp_stall;
  assign req_stall  = skid_valid;

  // One-second increment in mixed radix
  always_comb begin
    at_max   = (cnt == CNT_MAX);
    tick_cnt = cnt;
    if (cnt.seconds != 6'd59) begin
      tick_cnt.seconds = cnt.seconds + 6'd1;
    end else begin
      tick_cnt.seconds = '0;
      if (cnt.minutes != 6'd59) begin
        tick_cnt.minutes = cnt.minutes + 6'd1;
      end else begin
        tick_cnt.minutes = '0;
        if (cnt.hours != 5'd23) begin
          tick_cnt.hours = cnt.hours + 5'd1;
        end else begin
          tick_cnt.hours = '0;
          tick_cnt.days  = cnt.days + DAY_BITS'(1);
        end
      end
    end
  end

  // Field write carries: byte split by 60 or 24, quotient added to the next field up, wraps rippling on to the days
  always_comb begin
    q60_d  = div60(data);
    r60_d  = rem60(data);
    q24_d  = div24(data);
    r24_d  = rem24(data);
    m_sum  = {1'b0, cnt.minutes} + {4'd0, q60_d};
    m_wrap = (m_sum >= 7'd60);
    m_val  = m_wrap ? 6'(m_sum - 7'd60) : m_sum[5:0];
    hour_add = (reg_address == REG_SECONDS) ? {2'd0, m_wrap} : q60_d;
    h_sum  = {1'b0, cnt.hours} + {3'd0, hour_add};
    h_wrap = (h_sum >= 6'd24);
    h_val  = h_wrap ? 5'(h_sum - 6'd24) : h_sum[4:0];
    day_add = (reg_address == REG_HOURS) ? q24_d : {3'd0, h_wrap};
    d_sum  = {1'b0, cnt.days} + {{(DAY_BITS - 3){1'b0}}, day_add};
  end

  // Request decode and state update
  always_comb begin
    cnt_next             = cnt;
    latched_seconds_next = latched_seconds;
    latched_minutes_next = latched_minutes;
    latched_hours_next   = latched_hours;
    latched_days_next    = latched_days;
    last_latch_byte_next = last_latch_byte;
    halted_next          = halted;
    day_carry_next       = day_carry;
    rd_next              = '0;
    wide                 = {1'b0, cnt};
    sat_check            = 1'b0;
    fold                 = (cnt.days > DAY_BITS'(DAY_LIMIT));

    unique case (op)
      OP_TICK: begin
        if (!halted && !at_max) begin
          cnt_next = tick_cnt;
        end
      end
      OP_LATCH: begin
        if (last_latch_byte == 8'd0 && data == 8'd1) begin
          latched_seconds_next = cnt.seconds;
          latched_minutes_next = cnt.minutes;
          latched_hours_next   = cnt.hours;
          latched_days_next    = cnt.days[8:0];
        end
        last_latch_byte_next = data;
      end
      OP_READ: begin
        unique case (reg_address)
          REG_SECONDS: rd_next = {2'd0, latched_seconds};
          REG_MINUTES: rd_next = {2'd0, latched_minutes};
          REG_HOURS:   rd_next = {3'd0, latched_hours};
          REG_DAY_LOW: rd_next = latched_days[7:0];
          REG_DAY_HIGH: begin
            // fold days past the 9-bit range back by 512 and flag carry
            if (fold) begin
              cnt_next.days  = cnt.days - DAY_BITS'(DAY_FOLD);
              day_carry_next = 1'b1;
            end
            rd_next = {day_carry || fold, halted, 5'd0, latched_days[8]};
          end
          default: rd_next = '0;
        endcase
      end
      OP_WRITE: begin
        if (reg_address == REG_DAY_HIGH) begin
          if (halted) begin
            wide.days[8] = data[0];
            sat_check    = 1'b1;
          end
          halted_next    = data[6];
          day_carry_next = data[7];
        end else if (halted) begin
          unique case (reg_address)
            REG_SECONDS: begin
              wide.seconds = r60_d;
              wide.minutes = m_val;
              wide.hours   = h_val;
              wide.days    = d_sum;
              sat_check    = 1'b1;
            end
            REG_MINUTES: begin
              wide.minutes = r60_d;
              wide.hours   = h_val;
              wide.days    = d_sum;
              sat_check    = 1'b1;
            end
            REG_HOURS: begin
              wide.hours = r24_d;
              wide.days  = d_sum;
              sat_check  = 1'b1;
            end
            REG_DAY_LOW: begin
              wide.days[7:0] = data;
              sat_check      = 1'b1;
            end
            default: sat_check = 1'b0;
          endcase
        end
      end
      default: rd_next = '0;
    endcase

    // saturate a written count at the largest value
    if (sat_check) begin
      cnt_next = above_max(wide) ? CNT_MAX : cnt_t'(wide[$bits(cnt_t)-1:0]);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt             <= '0;
      latched_seconds <= '0;
      latched_minutes <= '0;
      latched_hours   <= '0;
      latched_days    <= '0;
      last_latch_byte <= '0;
      halted          <= 1'b0;
      day_carry       <= 1'b0;
    end else if (req_accept) begin
      cnt             <= cnt_next;
      latched_seconds <= latched_seconds_next;
      latched_minutes <= latched_minutes_next;
      latched_hours   <= latched_hours_next;
      latched_days    <= latched_days_next;
      last_latch_byte <= last_latch_byte_next;
      halted          <= halted_next;
      day_carry       <= day_carry_next;
    end
  end

  // Two-entry response buffer: output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (rsp_take) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (req_accept) begin
      if (!rsp_valid || rsp_take) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (rsp_take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (rsp_take) begin
        read_data <= skid_data;
      end
    end else if (req_accept) begin
      if (!rsp_valid || rsp_take) begin
        read_data <= rd_next;
      end else begin
        skid_data <= rd_next;
      end
    end
  end

  // Checks
  `CRTC_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid || rsp_valid || rst,
    "skid entry holds a response while the output register is empty")
  `CRTC_ASSERT(a_count_in_range, !above_max({1'b0, cnt}),
    "clock count above its largest value")
  `CRTC_ASSERT(a_fields_normal,
    (cnt.seconds < 6'd60) && (cnt.minutes < 6'd60) && (cnt.hours < 5'd24),
    "time of day field out of range")
  `CRTC_ASSERT(a_halt_freezes_tick,
    (req_accept && op == OP_TICK && halted) |=> $stable(cnt),
    "tick advanced a halted clock")
  `CRTC_ASSERT(a_skid_drains, (skid_valid && rsp_take) |=> !skid_valid && rsp_valid,
    "skid entry not moved to the output register")

endmodule
